// ===== design/rdsc_pkg.sv =====
// Package for the radix digit string converter.
// Holds the shared sizes, the sequencer state type, control structs and the glyph function.
// No dependencies.
`default_nettype none

package rdsc_pkg;

  // Default width of the converted number
  localparam int VALUE_BITS_DEF = 32;

  // Fixed port widths
  localparam int VALUE_W = 32;
  localparam int BASE_W  = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Base saturation bounds
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_EMIT
  } seq_state_t;

  // Digit stack control
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Digit value to uppercase ASCII
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < 4'd10) begin
      g = {3'b011, d};
    end else begin
      g = 7'd55 + {3'b000, d};
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== design/rdsc_div_unit.sv =====
// Iterative restoring divider: one quotient bit per cycle, divisor up to 16.
// Uses rdsc_pkg for widths and the status struct.
`default_nettype none

module rdsc_div_unit #(
  parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [VALUE_BITS-1:0]              dividend,
  input  wire logic [rdsc_pkg::BASE_W-1:0]        divisor,
  output logic [VALUE_BITS-1:0]                   quotient,
  output logic [rdsc_pkg::DIGIT_W-1:0]            remainder,
  output rdsc_pkg::div_stat_t                     stat
);

  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  logic [CNT_W-1:0]               cnt;
  logic                           busy;
  logic                           done;
  logic [rdsc_pkg::BASE_W-1:0]    trial;
  logic                           fits;

  // Partial remainder with the next dividend bit shifted in
  assign trial = {remainder, quotient[VALUE_BITS-1]};
  assign fits  = (trial >= divisor);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_LAST;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: shift quotient left, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (fits) begin
        remainder <= rdsc_pkg::DIGIT_W'(trial - divisor);
      end else begin
        remainder <= trial[rdsc_pkg::DIGIT_W-1:0];
      end
      quotient <= {quotient[VALUE_BITS-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== design/rdsc_digit_stack.sv =====
// Digit stack: memory of remainder digits, pushed low digit first, popped high digit first.
// Read data is registered. Uses rdsc_pkg for the control struct and digit width.
`default_nettype none

module rdsc_digit_stack #(
  parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rdsc_pkg::stk_ctrl_t            ctrl,
  input  wire logic [rdsc_pkg::DIGIT_W-1:0]   wr_digit,
  output logic [rdsc_pkg::DIGIT_W-1:0]        rd_digit,
  output logic                                empty,
  output logic [$clog2(VALUE_BITS+1)-1:0]     count
);

  localparam int PTR_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  logic [rdsc_pkg::DIGIT_W-1:0] mem [VALUE_BITS];
  logic [PTR_W-1:0]             count_dec;

  assign count_dec = count - 1'b1;
  assign empty     = (count == '0);

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      count <= count_dec;
    end
  end

  // Storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[ADDR_W-1:0]] <= wr_digit;
    end
    if (ctrl.pop) begin
      rd_digit <= mem[count_dec[ADDR_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== design/radix_digit_string_converter.sv =====
// Radix digit string converter top level: sequencer, divider and digit stack.
// Depends on rdsc_pkg, rdsc_div_unit and rdsc_digit_stack.
//
// Input channel (in_valid/in_stall): one word carries value and base. Bits of
// value above VALUE_BITS are ignored; base is clamped to 2..16. in_stall stays
// high from the accepted word until its last character has been taken.
// Output channel (out_valid/out_stall): one word per ASCII digit, most
// significant first, no leading zeros; last marks the final character. Zero
// gives a single '0'. While out_stall is high the character is held.
// For each number, each digit passes through the shared one-bit-per-cycle
// divider, then the top of the stack is read, then one character per cycle
// while out_stall is low. The divider sets the rate. Reset returns the
// sequencer to idle and empties the stack; stored digits are not cleared.
`default_nettype none

module radix_digit_string_converter #(
  parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rdsc_pkg::VALUE_W-1:0]     value,
  input  wire logic [rdsc_pkg::BASE_W-1:0]      base,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rdsc_pkg::CHAR_W-1:0]           digit_char,
  output logic                                  last
);

  localparam int PTR_W = $clog2(VALUE_BITS + 1);

  rdsc_pkg::seq_state_t           state;
  rdsc_pkg::seq_state_t           state_next;
  rdsc_pkg::stk_ctrl_t            stk_ctrl;
  rdsc_pkg::div_stat_t            div_stat;
  logic [rdsc_pkg::BASE_W-1:0]    base_sat;
  logic [rdsc_pkg::BASE_W-1:0]    divisor;
  logic [VALUE_BITS-1:0]          value_masked;
  logic [VALUE_BITS-1:0]          dividend;
  logic [VALUE_BITS-1:0]          quotient;
  logic [rdsc_pkg::DIGIT_W-1:0]   remainder;
  logic [rdsc_pkg::DIGIT_W-1:0]   rd_digit;
  logic                           stk_empty;
  logic [PTR_W-1:0]               stk_count;
  logic                           div_start;
  logic                           in_accept;
  logic                           out_accept;
  logic                           quot_zero;

  // Mask or extend the input value to VALUE_BITS
  if (VALUE_BITS >= rdsc_pkg::VALUE_W) begin : g_value_ext
    assign value_masked = VALUE_BITS'(value);
  end else begin : g_value_cut
    assign value_masked = value[VALUE_BITS-1:0];
  end

  // Clamp base to 2..16
  always_comb begin
    priority if (base < rdsc_pkg::BASE_MIN) begin
      base_sat = rdsc_pkg::BASE_MIN;
    end else if (base > rdsc_pkg::BASE_MAX) begin
      base_sat = rdsc_pkg::BASE_MAX;
    end else begin
      base_sat = base;
    end
  end

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign quot_zero  = (quotient == '0);

  // Divisor held for the whole item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      divisor <= base_sat;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rdsc_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = rdsc_pkg::ST_DIV;
        end
      end
      rdsc_pkg::ST_DIV: begin
        if (div_stat.done && quot_zero) begin
          state_next = rdsc_pkg::ST_LOAD;
        end
      end
      rdsc_pkg::ST_LOAD: begin
        state_next = rdsc_pkg::ST_EMIT;
      end
      rdsc_pkg::ST_EMIT: begin
        if (out_accept && stk_empty) begin
          state_next = rdsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    div_start      = 1'b0;
    dividend       = quotient;
    stk_ctrl.clear = 1'b0;
    stk_ctrl.push  = 1'b0;
    stk_ctrl.pop   = 1'b0;
    unique case (state)
      rdsc_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        dividend       = value_masked;
        div_start      = in_valid;
        stk_ctrl.clear = in_valid;
      end
      rdsc_pkg::ST_DIV: begin
        stk_ctrl.push = div_stat.done;
        div_start     = div_stat.done && !quot_zero;
      end
      rdsc_pkg::ST_LOAD: begin
        stk_ctrl.pop = 1'b1;
      end
      rdsc_pkg::ST_EMIT: begin
        out_valid    = 1'b1;
        stk_ctrl.pop = !out_stall && !stk_empty;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  rdsc_div_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (div_stat)
  );

  rdsc_digit_stack #(
    .VALUE_BITS (VALUE_BITS)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (stk_ctrl),
    .wr_digit (remainder),
    .rd_digit (rd_digit),
    .empty    (stk_empty),
    .count    (stk_count)
  );

  // Output word
  assign digit_char = rdsc_pkg::digit_glyph(rd_digit);
  assign last       = stk_empty;

  // The divider only runs while digits are being produced
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == rdsc_pkg::ST_DIV))
    else $error("divider busy outside digit generation");

  // The stack never holds more digits than the value has bits
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_count <= PTR_W'(VALUE_BITS))
    else $error("digit stack overflow");

  // Taking the last character frees the input side on the next cycle
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_accept && last) |=> !in_stall)
    else $error("input not released after last character");

  // An accepted word starts the divider and blocks further input
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (in_stall && div_stat.busy && !out_valid))
    else $error("accepted word did not start conversion");

endmodule

`default_nettype wire

// ===== bench/radix_digit_string_converter_test.sv =====
// Self-checking bench for radix_digit_string_converter: directed extremes, then random words.
// A local digit-string predictor fills a queue of expected characters, checked at the output.
// Depends on rdsc_pkg and radix_digit_string_converter.
`default_nettype none

module radix_digit_string_converter_test;

  localparam int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF;
  localparam logic [63:0] VALUE_MASK =
    (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
  // Digit glyphs, leftmost character in the top byte
  localparam logic [8*16-1:0] GLYPH_SET = "0123456789ABCDEF";
  // Longest correct gap without a handshake comes from base 2, 32 digits
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int ITEMS_PER_PHASE = 62;

  typedef struct packed {
    logic [rdsc_pkg::CHAR_W-1:0] ch;
    logic                        fin;
  } char_word_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [rdsc_pkg::VALUE_W-1:0]  value;
  logic [rdsc_pkg::BASE_W-1:0]   base;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [rdsc_pkg::CHAR_W-1:0]   digit_char;
  logic                          last;

  char_word_t pending_chars[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;
  int unsigned numbers_in     = 0;
  int unsigned chars_out      = 0;
  int unsigned fail_count     = 0;

  radix_digit_string_converter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .base       (base),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  always #6 clk = ~clk;

  // Clamp a raw base into the legal radix range
  function automatic int unsigned clamp_radix(input logic [rdsc_pkg::BASE_W-1:0] b);
    int unsigned r;
    r = 32'(b);
    if (r < 32'(rdsc_pkg::BASE_MIN)) r = 32'(rdsc_pkg::BASE_MIN);
    if (r > 32'(rdsc_pkg::BASE_MAX)) r = 32'(rdsc_pkg::BASE_MAX);
    return r;
  endfunction

  // Expected characters of one number, most significant first
  function automatic void predict_digit_string(input logic [rdsc_pkg::VALUE_W-1:0] v,
                                               input logic [rdsc_pkg::BASE_W-1:0] b);
    logic [63:0]                 n;
    logic [63:0]                 rem;
    int unsigned                 radix;
    logic [rdsc_pkg::CHAR_W-1:0] digits[$];
    char_word_t                  w;
    n = {32'd0, v} & VALUE_MASK;
    radix = clamp_radix(b);
    if (n == 64'd0) digits.push_back(GLYPH_SET[8*15 +: rdsc_pkg::CHAR_W]);
    while (n != 64'd0) begin
      rem = n % radix;
      digits.push_front(GLYPH_SET[8*(15 - rem[3:0]) +: rdsc_pkg::CHAR_W]);
      n = n / radix;
    end
    foreach (digits[i]) begin
      w.ch  = digits[i];
      w.fin = (i == digits.size() - 1);
      pending_chars.push_back(w);
    end
  endfunction

  // Random value: full range, small, or at a digit-count boundary of the base
  function automatic logic [rdsc_pkg::VALUE_W-1:0] pick_value(
      input logic [rdsc_pkg::BASE_W-1:0] b);
    logic [63:0]                  p;
    logic [rdsc_pkg::VALUE_W-1:0] v;
    int unsigned                  radix;
    radix = clamp_radix(b);
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = rdsc_pkg::VALUE_W'($urandom_range(255));
      default: begin
        p = 64'd1;
        repeat ($urandom_range(1, 31)) begin
          if (p * radix <= 64'hFFFF_FFFF) p = p * radix;
        end
        v = p[rdsc_pkg::VALUE_W-1:0] - rdsc_pkg::VALUE_W'($urandom_range(1));
      end
    endcase
    return v;
  endfunction

  // Send one word; inputs move on the falling edge
  task automatic send_number(input logic [rdsc_pkg::VALUE_W-1:0] v,
                             input logic [rdsc_pkg::BASE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    base     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_random_numbers(input int unsigned count);
    logic [rdsc_pkg::BASE_W-1:0] b;
    repeat (count) begin
      // Mostly legal bases, some out of range to exercise clamping
      b = ($urandom_range(9) < 7) ? rdsc_pkg::BASE_W'($urandom_range(2, 16))
                                  : rdsc_pkg::BASE_W'($urandom_range(31));
      send_number(pick_value(b), b);
    end
  endtask

  // Receiver stall, redrawn every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Scoreboard: check outputs first, then record newly accepted numbers
  always @(posedge clk) begin
    char_word_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        chars_out++;
        if (pending_chars.size() == 0) begin
          $error("unexpected word: digit_char %0d last %0b", digit_char, last);
          fail_count++;
        end else begin
          w = pending_chars.pop_front();
          if (digit_char !== w.ch) begin
            $error("digit_char: expected %0d actual %0d", w.ch, digit_char);
            fail_count++;
          end
          if (last !== w.fin) begin
            $error("last: expected %0b actual %0b", w.fin, last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        numbers_in++;
        predict_digit_string(value, base);
      end
      // Idle count restarts on any handshake
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no word moved for %0d cycles, %0d characters outstanding",
             WATCHDOG_LIMIT, pending_chars.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Edges of the value range, every clamping case, letter digits
  task automatic test_directed_extremes;
    send_number(32'd0, 5'd10);
    send_number(32'd0, 5'd0);
    send_number(32'd1, 5'd2);
    send_number(32'hFFFF_FFFF, 5'd2);
    send_number(32'h8000_0000, 5'd2);
    send_number(32'hFFFF_FFFF, 5'd16);
    send_number(32'hFEDC_BA98, 5'd16);
    send_number(32'h0123_4567, 5'd16);
    send_number(32'd15, 5'd16);
    send_number(32'd10, 5'd11);
    send_number(32'hFFFF_FFFF, 5'd3);
    send_number(32'hFFFF_FFFF, 5'd10);
    send_number(32'd1_000_000_000, 5'd10);
    send_number(32'd255, 5'd0);
    send_number(32'd255, 5'd1);
    send_number(32'd255, 5'd17);
    send_number(32'hFFFF_FFFF, 5'd31);
    send_number(32'd0, 5'd31);
    send_number(32'd48, 5'd7);
    send_number(32'd224, 5'd15);
    send_number(32'h5555_5555, 5'd4);
    send_number(32'hAAAA_AAAA, 5'd8);
  endtask

  task automatic test_back_to_back;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_numbers(ITEMS_PER_PHASE);
  endtask

  task automatic test_sender_gaps;
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    run_random_numbers(ITEMS_PER_PHASE);
  endtask

  task automatic test_receiver_stalls;
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    run_random_numbers(ITEMS_PER_PHASE);
  endtask

  task automatic test_mixed_idling;
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random_numbers(ITEMS_PER_PHASE);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = '0;
    base      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    // Drain the outstanding characters, then a short quiet tail
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Run covered %0d numbers and %0d characters, bases 0 to 31 with clamping,",
             numbers_in, chars_out);
    $display("under back-to-back, sender-gap, receiver-stall and mixed flow control.");
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
